>>> design/first_fit_free_list_allocator_macros.svh
// ----------------------------------------------------------------------------
// First-fit allocator assertion macros
// Shorthand for clocked assertions on clk with asynchronous reset arst_n.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FFA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FFA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/ffa_pkg.sv
// ----------------------------------------------------------------------------
// First-fit allocator package
// Sizes, entry and write-port types, codes and ring pointer helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package ffa_pkg;

	localparam int FREE_ENTRIES = 16;
	localparam int IDX_W = (FREE_ENTRIES > 1) ? $clog2(FREE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(FREE_ENTRIES + 1);

	localparam int ADDR_W = 32;
	localparam int SIZE_W = 25;
	localparam int REQ_W = 24;
	localparam int STAT_W = 2;

	localparam int IN_DATA_W = 88;
	localparam int OUT_DATA_W = 64;

	localparam logic [ADDR_W-1:0] HDR_BYTES = 32'd8;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE = 1'b1;

	localparam logic [STAT_W-1:0] STAT_OK = 2'd0;
	localparam logic [STAT_W-1:0] STAT_OOM = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

	localparam logic CFG_HEAP_BASE = 1'b0;
	localparam logic CFG_HEAP_LIMIT = 1'b1;

	typedef struct packed {
		logic [ADDR_W-1:0] start;
		logic [SIZE_W-1:0] bytes;
	} entry_t;

	typedef struct packed {
		logic en;
		logic [IDX_W-1:0] ptr;
		entry_t ent;
	} wr_req_t;

	function automatic logic [IDX_W-1:0] ptr_next(input logic [IDX_W-1:0] p);
		if (p == IDX_W'(FREE_ENTRIES - 1)) begin
			return '0;
		end
		return p + IDX_W'(1);
	endfunction

	function automatic logic [IDX_W-1:0] ptr_prev(input logic [IDX_W-1:0] p);
		if (p == '0) begin
			return IDX_W'(FREE_ENTRIES - 1);
		end
		return p - IDX_W'(1);
	endfunction

endpackage

`default_nettype wire

>>> design/first_fit_free_list_allocator.sv
// ----------------------------------------------------------------------------
// First-fit free-list allocator
// Serves allocate and free requests against a ring-held ordered free list
// with bump allocation past the break when no free block fits.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake              Payload
//  s_       in         s_tvalid / s_tready    tuser mode, tdata request fields
//  m_       out        m_tvalid / m_tready    tdata result fields
//  cfg_     in         cfg_we                 cfg_idx, cfg_data
//
//  A free that finds room is written to the ring in the cycle that accepts it.
//  An allocate primes the read port and scans from the head; a hit at entry
//  i > 0 shifts the i entries ahead of it up one slot, a miss tries the break.
//  The single read port of the ring paces scan and shift: one entry per cycle.
//  Reset empties the list and clears the break. A stalled output holds the
//  block in its final state until the result beat is taken.
//
`default_nettype none
`include "first_fit_free_list_allocator_macros.svh"

module first_fit_free_list_allocator (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_tvalid,
	output logic                             s_tready,
	input  wire                              s_tuser,  // mode
	input  wire  [ffa_pkg::IN_DATA_W-1:0]    s_tdata,  // req_size, user_addr, header_size
	output logic                             m_tvalid,
	input  wire                              m_tready,
	output logic [ffa_pkg::OUT_DATA_W-1:0]   m_tdata,  // out_addr, granted_size, status
	input  wire                              cfg_we,
	input  wire                              cfg_idx,
	input  wire  [ffa_pkg::ADDR_W-1:0]       cfg_data
);
	import ffa_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRIME,
		ST_SCAN,
		ST_SH_PRIME,
		ST_SHIFT,
		ST_BUMP1,
		ST_BUMP2,
		ST_EMIT
	} state_t;

	state_t st_q;

	logic [ADDR_W-1:0] base_q;
	logic [ADDR_W-1:0] limit_q;
	logic [ADDR_W-1:0] brk_q;
	logic [IDX_W-1:0]  hd_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [IDX_W-1:0]  rd_ptr_q;
	logic [IDX_W-1:0]  cur_q;
	logic [IDX_W-1:0]  dst_q;
	logic [CNT_W-1:0]  pos_q;
	logic [CNT_W-1:0]  rem_q;
	logic [SIZE_W-1:0] need_q;
	logic [ADDR_W:0]   start_q;

	logic [ADDR_W-1:0] res_addr_q;
	logic [SIZE_W-1:0] res_size_q;
	logic [STAT_W-1:0] res_stat_q;

	logic              m_tvalid_q;
	logic [ADDR_W-1:0] out_addr_q;
	logic [SIZE_W-1:0] out_size_q;
	logic [STAT_W-1:0] out_stat_q;

	logic [REQ_W-1:0]  in_req;
	logic [ADDR_W-1:0] in_uaddr;
	logic [SIZE_W-1:0] in_hsize;
	logic              accept;
	logic [SIZE_W-1:0] need_c;
	logic [ADDR_W+1:0] end_c;

	entry_t  rd_data;
	wr_req_t wr;

	assign in_req = s_tdata[REQ_W-1:0];
	assign in_uaddr = s_tdata[REQ_W+ADDR_W-1:REQ_W];
	assign in_hsize = s_tdata[REQ_W+ADDR_W+SIZE_W-1:REQ_W+ADDR_W];

	assign s_tready = (st_q == ST_IDLE);
	assign accept = s_tvalid && s_tready;
	assign need_c = ({1'b0, in_req} + SIZE_W'(15)) & ~SIZE_W'(7);
	assign end_c = {1'b0, start_q} + {{(ADDR_W+2-SIZE_W){1'b0}}, need_q};

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {{(OUT_DATA_W-ADDR_W-SIZE_W-STAT_W){1'b0}}, out_stat_q, out_size_q,
		out_addr_q};

	always_comb begin
		wr = '0;
		if (accept && s_tuser == MODE_FREE && cnt_q != CNT_W'(FREE_ENTRIES)) begin
			wr.en = 1'b1;
			wr.ptr = ptr_prev(hd_q);
			wr.ent.start = in_uaddr - HDR_BYTES;
			wr.ent.bytes = in_hsize;
		end else if (st_q == ST_SHIFT) begin
			wr.en = 1'b1;
			wr.ptr = dst_q;
			wr.ent = rd_data;
		end
	end

	ffa_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd_ptr  (rd_ptr_q),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			limit_q <= '1;
		end else if (cfg_we) begin
			if (cfg_idx == CFG_HEAP_BASE) begin
				base_q <= cfg_data;
			end
			if (cfg_idx == CFG_HEAP_LIMIT) begin
				limit_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			brk_q <= '0;
			hd_q <= '0;
			cnt_q <= '0;
			rd_ptr_q <= '0;
			cur_q <= '0;
			dst_q <= '0;
			pos_q <= '0;
			rem_q <= '0;
			need_q <= '0;
			start_q <= '0;
			res_addr_q <= '0;
			res_size_q <= '0;
			res_stat_q <= STAT_OK;
			out_addr_q <= '0;
			out_size_q <= '0;
			out_stat_q <= STAT_OK;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && st_q != ST_EMIT) begin
				m_tvalid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (accept) begin
						if (s_tuser == MODE_FREE) begin
							res_addr_q <= '0;
							res_size_q <= '0;
							if (cnt_q == CNT_W'(FREE_ENTRIES)) begin
								res_stat_q <= STAT_FULL;
							end else begin
								res_stat_q <= STAT_OK;
								hd_q <= ptr_prev(hd_q);
								cnt_q <= cnt_q + CNT_W'(1);
							end
							st_q <= ST_EMIT;
						end else begin
							need_q <= need_c;
							rd_ptr_q <= hd_q;
							cur_q <= hd_q;
							pos_q <= '0;
							st_q <= (cnt_q == '0) ? ST_BUMP1 : ST_PRIME;
						end
					end
				end
				ST_PRIME: begin
					rd_ptr_q <= ptr_next(rd_ptr_q);
					st_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (rd_data.bytes >= need_q) begin
						res_addr_q <= rd_data.start + HDR_BYTES;
						res_size_q <= rd_data.bytes;
						res_stat_q <= STAT_OK;
						if (pos_q == '0) begin
							hd_q <= ptr_next(hd_q);
							cnt_q <= cnt_q - CNT_W'(1);
							st_q <= ST_EMIT;
						end else begin
							dst_q <= cur_q;
							rd_ptr_q <= ptr_prev(cur_q);
							rem_q <= pos_q;
							st_q <= ST_SH_PRIME;
						end
					end else if (pos_q + CNT_W'(1) == cnt_q) begin
						st_q <= ST_BUMP1;
					end else begin
						pos_q <= pos_q + CNT_W'(1);
						cur_q <= rd_ptr_q;
						rd_ptr_q <= ptr_next(rd_ptr_q);
					end
				end
				ST_SH_PRIME: begin
					rd_ptr_q <= ptr_prev(rd_ptr_q);
					st_q <= ST_SHIFT;
				end
				ST_SHIFT: begin
					dst_q <= ptr_prev(dst_q);
					rd_ptr_q <= ptr_prev(rd_ptr_q);
					rem_q <= rem_q - CNT_W'(1);
					if (rem_q == CNT_W'(1)) begin
						hd_q <= ptr_next(hd_q);
						cnt_q <= cnt_q - CNT_W'(1);
						st_q <= ST_EMIT;
					end
				end
				ST_BUMP1: begin
					start_q <= {1'b0, base_q} + {1'b0, brk_q};
					st_q <= ST_BUMP2;
				end
				ST_BUMP2: begin
					if (end_c > {2'b00, limit_q}) begin
						res_addr_q <= '0;
						res_size_q <= '0;
						res_stat_q <= STAT_OOM;
					end else begin
						res_addr_q <= start_q[ADDR_W-1:0] + HDR_BYTES;
						res_size_q <= need_q;
						res_stat_q <= STAT_OK;
						brk_q <= brk_q + {{(ADDR_W-SIZE_W){1'b0}}, need_q};
					end
					st_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!m_tvalid_q || m_tready) begin
						out_addr_q <= res_addr_q;
						out_size_q <= res_size_q;
						out_stat_q <= res_stat_q;
						m_tvalid_q <= 1'b1;
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	`FFA_ASSERT_NEXT(a_free_push_count,
		accept && s_tuser == MODE_FREE && cnt_q < CNT_W'(FREE_ENTRIES),
		cnt_q == $past(cnt_q) + CNT_W'(1),
		"Accepted free did not grow the list by one entry.")
	`FFA_ASSERT_NOW(a_scan_in_range, st_q == ST_SCAN, pos_q < cnt_q,
		"Scan position ran past the valid entries.")
	`FFA_ASSERT_NOW(a_oom_zero_payload, m_tvalid_q && out_stat_q == STAT_OOM,
		out_addr_q == '0 && out_size_q == '0,
		"Out-of-memory result carries a nonzero address or size.")
	`FFA_ASSERT_NEXT(a_shift_end_pop, st_q == ST_SHIFT && rem_q == CNT_W'(1),
		st_q == ST_EMIT && cnt_q == $past(cnt_q) - CNT_W'(1),
		"Gap close did not finish with one entry removed.")

endmodule

`default_nettype wire

>>> design/ffa_store.sv
// ----------------------------------------------------------------------------
// First-fit allocator free-list store
// Ring of free entries with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_store (
	input  wire                          clk,
	input  wire  ffa_pkg::wr_req_t       wr,
	input  wire  [ffa_pkg::IDX_W-1:0]    rd_ptr,
	output ffa_pkg::entry_t              rd_data
);
	import ffa_pkg::*;

	entry_t mem [FREE_ENTRIES];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.ptr] <= wr.ent;
		end
		rd_data <= mem[rd_ptr];
	end

endmodule

`default_nettype wire
